// File: hw/rtl/olad_pkg.sv
package olad_pkg;

   // List capacity and derived widths
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Request action codes
   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_LIST   = 2'd2;

   // Response status codes
   localparam logic [2:0] STAT_INSERTED = 3'd0;
   localparam logic [2:0] STAT_DELETED  = 3'd1;
   localparam logic [2:0] STAT_NOTFOUND = 3'd2;
   localparam logic [2:0] STAT_EMPTY    = 3'd3;
   localparam logic [2:0] STAT_FULL     = 3'd4;
   localparam logic [2:0] STAT_LISTED   = 3'd5;

   // Controller to datapath commands
   typedef struct packed {
      logic       accept;
      logic       append;
      logic       clear_idx;
      logic       inc_idx;
      logic       shift;
      logic       dec_count;
      logic       rsp_load;
      logic [2:0] rsp_status;
      logic       rsp_listed;
      logic       rsp_last;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] action;
      logic       empty;
      logic       full;
      logic       match;
      logic       at_last;
   } dp_stat_type;

endpackage

// File: hw/rtl/olad_ctrl.sv
module olad_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  olad_pkg::dp_stat_type stat,
   output olad_pkg::dp_cmd_type  cmd
);
   import olad_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_SHIFT,
      S_LIST
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action) inside
               ACT_APPEND: begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  state_in     = S_IDLE;
                  if (stat.full) begin
                     cmd.rsp_status = STAT_FULL;
                  end else begin
                     cmd.append     = 1'b1;
                     cmd.rsp_status = STAT_INSERTED;
                  end
               end
               ACT_DELETE, ACT_LIST: begin
                  if (stat.empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_last   = 1'b1;
                     cmd.rsp_status = STAT_EMPTY;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.clear_idx = 1'b1;
                     state_in      = (stat.action == ACT_LIST) ? S_LIST : S_SEARCH;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         // walk until the first match or the end of the list
         S_SEARCH: begin
            if (stat.match) begin
               state_in = S_SHIFT;
            end else if (stat.at_last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_last   = 1'b1;
               cmd.rsp_status = STAT_NOTFOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         // close the gap one entry per cycle
         S_SHIFT: begin
            if (stat.at_last) begin
               cmd.dec_count  = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_last   = 1'b1;
               cmd.rsp_status = STAT_DELETED;
               state_in       = S_IDLE;
            end else begin
               cmd.shift   = 1'b1;
               cmd.inc_idx = 1'b1;
            end
         end
         S_LIST: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_listed = 1'b1;
            cmd.rsp_status = STAT_LISTED;
            cmd.rsp_last   = stat.at_last;
            if (stat.at_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: hw/rtl/olad_dp.sv
module olad_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_action,
   input  logic signed [31:0]   req_value,
   input  olad_pkg::dp_cmd_type  cmd,
   output olad_pkg::dp_stat_type stat,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_status,
   output logic signed [31:0]   rsp_entry,
   output logic                 rsp_last
);
   import olad_pkg::*;

   logic [31:0]       mem [DEPTH];
   logic [1:0]        action_ff;
   logic [31:0]       value_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [31:0]       rd_data;
   logic [CNT_W-1:0]  idx_next_cnt;
   logic              rsp_strobe_ff;
   logic [2:0]        rsp_status_ff;
   logic [31:0]       rsp_entry_ff;
   logic              rsp_last_ff;

   // Single read port: the next entry while shifting, else the current one
   assign rd_addr      = cmd.shift ? (idx_ff + IDX_W'(1)) : idx_ff;
   assign rd_data      = mem[rd_addr];
   assign idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);

   // Status to the controller
   always_comb begin
      stat.action  = action_ff;
      stat.empty   = (count_ff == '0);
      stat.full    = (count_ff == CNT_W'(DEPTH));
      stat.match   = (rd_data == value_ff);
      stat.at_last = (idx_next_cnt == count_ff);
   end

   // Latched request
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
   end

   // Entry storage: append at tail, or move one entry down
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[IDX_W-1:0]] <= value_ff;
      end else if (cmd.shift) begin
         mem[idx_ff] <= rd_data;
      end
   end

   // Fill count and walk index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.dec_count) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.clear_idx) begin
            idx_ff <= '0;
         end else if (cmd.inc_idx) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_entry_ff  <= cmd.rsp_listed ? rd_data : 32'd0;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_last   = rsp_last_ff;

   // Fill count never passes capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("fill count above capacity");

   // Walk index stays inside the filled part while it is used
   assert property (@(posedge clock) disable iff (reset)
      (cmd.inc_idx || cmd.shift) |-> (idx_next_cnt < count_ff))
      else $error("walk index past fill count");

endmodule

// File: hw/rtl/ordered_list_append_delete_core.sv
// Ordered list core: append at tail, delete first match, list all entries.
// Append gives one response (inserted or full); delete gives one (deleted, not found or empty);
// action 3 gives none. Delete walks to the first match, then shifts the later entries down.
// Listing: one entry per cycle, the last marked with rsp_last; an empty list gives one status.
// One request at a time; busy drops as the final response is strobed, so the next request
// is taken at that edge; the receiver cannot stall. Sync reset empties the list.
module ordered_list_append_delete_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_entry,
   output logic               rsp_last
);
   import olad_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        busy_int;

   // Sequencer
   olad_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy_int),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Storage, walk index and response registers
   olad_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_action (req_action),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_entry  (rsp_entry),
      .rsp_last   (rsp_last)
   );

   assign busy = busy_int;

   // A taken request keeps the core busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request taken but core not busy");

   // Status-only responses carry a zero entry and the last marker
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_LISTED)) |-> (rsp_last && (rsp_entry == 32'sd0)))
      else $error("status response malformed");

   // The final response of a request frees the core; earlier ones do not
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last == !busy))
      else $error("busy out of step with last response");

endmodule
